[hdl/dtq_pkg.sv]
`default_nettype none
package dtq_pkg;

  localparam int TIME_W = 48;
  localparam int ID_W   = 8;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_DISABLED = 3'd1,
    ST_FULL     = 3'd2,
    ST_FIRED    = 3'd3,
    ST_NOTREADY = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic {
    REQ_ENQUEUE = 1'b0,
    REQ_POLL    = 1'b1
  } req_type_t;

  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   task_id;
    logic              repeat_req;
    logic [TIME_W-1:0] period;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ID_W-1:0]   fired_id;
    logic [TIME_W-1:0] head_deadline;
  } resp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_POP,
    S_RELOAD,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } ctl_state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_req;
    logic rd_head;
    logic pop_step;
    logic load_reload;
    logic scan_step;
    logic shift_step;
    logic write_new;
    logic set_resp;
    logic [2:0] resp_status;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic req_poll;
    logic empty;
    logic full;
    logic head_ready;
    logic head_repeat;
    logic pop_done;
    logic scan_done;
    logic shift_done;
  } dp_stat_t;

endpackage
`default_nettype wire

[hdl/dtq_datapath.sv]
`default_nettype none
// Sorted store held in memories. Insertion scans down from the tail, moving
// each later entry up one slot; pop shifts the store down one entry per cycle.
module dtq_datapath #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire              clk,
  input  wire              rst,
  input  dtq_pkg::req_t    req,
  input  dtq_pkg::dp_cmd_t cmd,
  output dtq_pkg::dp_stat_t stat,
  output dtq_pkg::resp_t   resp
);
  import dtq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [TIME_W-1:0] TMAX = '1;

  typedef struct packed {
    logic [TIME_W-1:0] dl;
    logic [TIME_W-1:0] per;
    logic [ID_W-1:0]   id;
    logic              rep;
    logic [15:0]       order;
  } entry_t;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;

  logic [CW-1:0] count, count_next;
  logic [15:0]   serial, serial_next;
  logic [CW-1:0] pos, pos_next;   // insert scan position / pop index
  logic          req_poll, req_poll_next;
  logic [TIME_W-1:0] now;
  entry_t        newe;       // entry being inserted
  entry_t        head;
  logic          rd_valid, rd_valid_next;
  logic          pop_last;
  resp_t         r;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;
  logic [AW-1:0] mem_ra;
  logic [TIME_W:0] sum;

  assign sum = {1'b0, head.dl} + {1'b0, head.per};
  assign pop_last = !(pos < count) && !rd_valid;

  // read address: pop walks upward, scan walks downward
  always_comb begin
    mem_ra = '0;
    if (cmd.scan_step || cmd.shift_step) begin
      mem_ra = AW'(pos - CW'(1));
    end else if (cmd.pop_step) begin
      mem_ra = AW'(pos);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_data;
    if (cmd.shift_step) begin
      mem_we = 1'b1;
      mem_wa = AW'(pos);
    end else if (cmd.pop_step && rd_valid) begin
      mem_we = 1'b1;
      mem_wa = AW'(pos - CW'(2));
    end else if (cmd.write_new) begin
      mem_we = 1'b1;
      mem_wa = AW'(pos);
      mem_wd = newe;
      mem_wd.order = serial;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  always_comb begin
    count_next    = count;
    serial_next   = serial;
    pos_next      = pos;
    rd_valid_next = 1'b0;
    req_poll_next = req_poll;
    if (cmd.load_req) begin
      req_poll_next = req.req_type;
      pos_next      = count;
    end else if (cmd.rd_head) begin
      pos_next = CW'(1);
    end
    if (cmd.pop_step) begin
      pos_next = pos + CW'(1);
      if (pop_last) begin
        count_next = count - CW'(1);
      end else begin
        rd_valid_next = (pos < count);
      end
    end
    if (cmd.load_reload) begin
      pos_next = count;
    end
    if (cmd.scan_step) begin
      rd_valid_next = 1'b1;
    end
    if (cmd.shift_step) begin
      pos_next = pos - CW'(1);
    end
    if (cmd.write_new) begin
      count_next  = count + CW'(1);
      serial_next = serial + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      serial   <= '0;
      pos      <= '0;
      rd_valid <= 1'b0;
      req_poll <= 1'b0;
    end else begin
      count    <= count_next;
      serial   <= serial_next;
      pos      <= pos_next;
      rd_valid <= rd_valid_next;
      req_poll <= req_poll_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      now        <= req.deadline;
      newe.dl    <= req.deadline;
      newe.per   <= req.period;
      newe.id    <= req.task_id;
      newe.rep   <= req.repeat_req;
      newe.order <= '0;
    end else if (cmd.load_reload) begin
      newe.dl  <= sum[TIME_W] ? TMAX : sum[TIME_W-1:0];
      newe.per <= head.per;
      newe.id  <= head.id;
      newe.rep <= head.rep;
    end
    if (cmd.rd_head) begin
      head <= mem[0];
    end
    if (cmd.set_resp) begin
      r.status <= cmd.resp_status;
      if (cmd.resp_status == ST_FIRED) begin
        r.fired_id      <= head.id;
        r.head_deadline <= head.dl;
      end else if (cmd.resp_status == ST_NOTREADY) begin
        r.fired_id      <= '0;
        r.head_deadline <= head.dl;
      end else begin
        r.fired_id      <= '0;
        r.head_deadline <= '0;
      end
    end
  end

  assign resp = r;

  always_comb begin
    stat             = '0;
    stat.req_poll    = req_poll;
    stat.empty       = (count == '0);
    stat.full        = (count >= CW'(QUEUE_DEPTH));
    stat.head_ready  = !(now < head.dl);
    stat.head_repeat = head.rep;
    stat.pop_done    = cmd.pop_step && pop_last;
    // scan: rd_data holds entry pos-1 when rd_valid
    stat.scan_done   = (pos == '0);
    stat.shift_done  = rd_valid && !(rd_data.dl > newe.dl);
  end

endmodule
`default_nettype wire

[hdl/dtq_ctrl.sv]
`default_nettype none
module dtq_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire               enable,
  input  dtq_pkg::dp_stat_t stat,
  output dtq_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              done
);
  import dtq_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          cmd.rd_head  = 1'b1;
          state_next   = S_HEAD;
        end
      end
      S_HEAD: begin
        if (!stat.req_poll) begin
          if (!enable) begin
            cmd.set_resp = 1'b1; cmd.resp_status = ST_DISABLED; state_next = S_DONE;
          end else if (stat.full) begin
            cmd.set_resp = 1'b1; cmd.resp_status = ST_FULL; state_next = S_DONE;
          end else begin
            cmd.set_resp = 1'b1; cmd.resp_status = ST_QUEUED;
            cmd.load_reload = 1'b0;
            state_next = S_SCAN;
          end
        end else if (stat.empty) begin
          cmd.set_resp = 1'b1; cmd.resp_status = ST_EMPTY; state_next = S_DONE;
        end else if (!stat.head_ready) begin
          cmd.set_resp = 1'b1; cmd.resp_status = ST_NOTREADY; state_next = S_DONE;
        end else begin
          cmd.set_resp = 1'b1; cmd.resp_status = ST_FIRED;
          cmd.rd_head = 1'b1;
          state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.pop_step = 1'b1;
        if (stat.pop_done) begin
          state_next = (stat.head_repeat && enable) ? S_RELOAD : S_DONE;
        end
      end
      S_RELOAD: begin
        cmd.load_reload = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        // issue read of entry pos-1
        if (stat.scan_done) begin
          state_next = S_WRITE;
        end else begin
          cmd.scan_step = 1'b1;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_next = S_WRITE;
        end else begin
          cmd.shift_step = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_WRITE: begin
        cmd.write_new = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hdl/deadline_task_queue.sv]
`default_nettype none
// Drops, empty and not-ready results are answered from the head check; an
// insert scans down from the tail, a pop shifts the whole store down, and a
// fired repeating task is reinserted after its pop while enabled.
// Throughput: one transaction at a time; busy stays high through the strobe
// cycle, so the next start is taken in the cycle after it. The receiver cannot stall.
// Reset (rst, synchronous): queue emptied, enable cleared.
module deadline_task_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  output logic           busy,
  input  dtq_pkg::req_t  req,
  output logic           done,
  output dtq_pkg::resp_t resp,
  input  wire            cfg_valid,
  output logic           cfg_ready,
  input  wire            cfg_data
);
  import dtq_pkg::*;

  logic     enable;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // enable only changes between transactions
  assign cfg_ready = !busy && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enable <= cfg_data;
    end
  end

  dtq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .enable(enable),
    .stat(stat), .cmd(cmd), .busy(busy), .done(done)
  );

  dtq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .stat(stat), .resp(resp)
  );

endmodule
`default_nettype wire

[dv/tb_deadline_task_queue.sv]
`timescale 1ns / 1ps
module tb_deadline_task_queue;
  import dtq_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  resp_t resp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  deadline_task_queue i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .resp(resp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the task store, kept sorted with stable order on ties
  logic [TIME_W-1:0] sh_dl [DEPTH];
  logic [TIME_W-1:0] sh_per [DEPTH];
  logic [ID_W-1:0] sh_id [DEPTH];
  logic sh_rep [DEPTH];
  int sh_count = 0;
  logic sh_enable = 1'b0;

  resp_t pending_resp [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit no_gaps = 0;
  logic [TIME_W-1:0] now_ticks = '0;

  task automatic shadow_insert(logic [TIME_W-1:0] dl, logic [TIME_W-1:0] per,
                               logic [ID_W-1:0] id, logic rep);
    int pos;
    pos = sh_count;
    while (pos > 0 && sh_dl[pos-1] > dl) begin
      sh_dl[pos] = sh_dl[pos-1];
      sh_per[pos] = sh_per[pos-1];
      sh_id[pos] = sh_id[pos-1];
      sh_rep[pos] = sh_rep[pos-1];
      pos--;
    end
    sh_dl[pos] = dl;
    sh_per[pos] = per;
    sh_id[pos] = id;
    sh_rep[pos] = rep;
    sh_count++;
  endtask

  task automatic predict_queue(input req_t r, output resp_t e);
    logic [TIME_W-1:0] dl, per;
    logic [ID_W-1:0] id;
    logic rep;
    e = '0;
    if (r.req_type == REQ_ENQUEUE) begin
      if (!sh_enable) e.status = ST_DISABLED;
      else if (sh_count >= DEPTH) e.status = ST_FULL;
      else begin
        shadow_insert(r.deadline, r.period, r.task_id, r.repeat_req);
        e.status = ST_QUEUED;
      end
    end else if (sh_count == 0) begin
      e.status = ST_EMPTY;
    end else if (r.deadline < sh_dl[0]) begin
      e.status = ST_NOTREADY;
      e.head_deadline = sh_dl[0];
    end else begin
      dl = sh_dl[0];
      per = sh_per[0];
      id = sh_id[0];
      rep = sh_rep[0];
      for (int i = 1; i < sh_count; i++) begin
        sh_dl[i-1] = sh_dl[i];
        sh_per[i-1] = sh_per[i];
        sh_id[i-1] = sh_id[i];
        sh_rep[i-1] = sh_rep[i];
      end
      sh_count--;
      e.status = ST_FIRED;
      e.fired_id = id;
      e.head_deadline = dl;
      // reload saturates at the top of the time range
      if (rep && sh_enable)
        shadow_insert((per > TIME_MAX - dl) ? TIME_MAX : dl + per, per, id, rep);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", resp);
      end else begin
        resp_t e;
        e = pending_resp.pop_front();
        if (resp.status !== e.status || resp.fired_id !== e.fired_id ||
            resp.head_deadline !== e.head_deadline) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d id=%0d dl=%0d got st=%0d id=%0d dl=%0d",
                     e.status, e.fired_id, e.head_deadline,
                     resp.status, resp.fired_id, resp.head_deadline);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_req(input req_t r);
    resp_t e;
    if (!no_gaps && $urandom_range(99) < 11) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    req = r;
    do @(posedge clk); while (busy);
    predict_queue(r, e);
    pending_resp.push_back(e);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sh_enable = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic req_t make_req(logic kind, logic [TIME_W-1:0] t, logic [ID_W-1:0] id,
                                    logic rep, logic [TIME_W-1:0] per);
    req_t r;
    r.req_type = kind;
    r.deadline = t;
    r.task_id = id;
    r.repeat_req = rep;
    r.period = per;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  task automatic test_edge_cases();
    send_req(make_req(REQ_POLL, '0, '0, 1'b0, '0));           // empty queue
    send_req(make_req(REQ_ENQUEUE, 48'd5, 8'hff, 1'b1, 48'd1)); // dropped, disabled
    write_enable(1'b1);
    send_req(make_req(REQ_ENQUEUE, 48'd100, 8'h01, 1'b0, '0));
    send_req(make_req(REQ_ENQUEUE, 48'd100, 8'h02, 1'b0, '0)); // tie keeps order
    send_req(make_req(REQ_ENQUEUE, '0, 8'h00, 1'b1, TIME_MAX));
    send_req(make_req(REQ_ENQUEUE, TIME_MAX, 8'hff, 1'b1, TIME_MAX));
    send_req(make_req(REQ_ENQUEUE, 48'd50, 8'haa, 1'b1, 48'd30));
    send_req(make_req(REQ_POLL, '0, '0, 1'b0, '0));           // fires, reload saturates
    send_req(make_req(REQ_POLL, 48'd10, '0, 1'b0, '0));       // not ready
    send_req(make_req(REQ_POLL, 48'd80, '0, 1'b0, '0));       // fires, reload to 80
    send_req(make_req(REQ_POLL, 48'd100, '0, 1'b0, '0));
    write_enable(1'b0);
    send_req(make_req(REQ_POLL, 48'd200, '0, 1'b0, '0));      // fires a one-shot task
    send_req(make_req(REQ_POLL, 48'd200, '0, 1'b0, '0));
    write_enable(1'b1);
    for (int i = 0; i < 4; i++) send_req(make_req(REQ_POLL, TIME_MAX, '0, 1'b0, '0));
    write_enable(1'b0);
    for (int i = 0; i < 3; i++) send_req(make_req(REQ_POLL, TIME_MAX, '0, 1'b0, '0));
  endtask

  task automatic test_full_queue();
    write_enable(1'b1);
    no_gaps = 1;
    for (int i = 0; i < DEPTH + 2; i++)
      send_req(make_req(REQ_ENQUEUE, TIME_W'($urandom_range(1000)), ID_W'($urandom),
                        1'($urandom), TIME_W'($urandom)));
    no_gaps = 0;
    write_enable(1'b0);
    send_req(make_req(REQ_ENQUEUE, 48'd3, 8'h33, 1'b0, '0));  // disabled wins over full
    write_enable(1'b1);
    for (int i = 0; i < DEPTH + 4; i++)
      send_req(make_req(REQ_POLL, 48'd400 + TIME_W'(i * 20), '0, 1'b0, '0));
    write_enable(1'b0);
    while (sh_count != 0) send_req(make_req(REQ_POLL, TIME_MAX, '0, 1'b0, '0));
  endtask

  task automatic test_random_traffic();
    req_t r;
    write_enable(1'b1);
    now_ticks = '0;
    for (int n = 0; n < 600; n++) begin
      if (n == 200) write_enable(1'b0);
      if (n == 240) write_enable(1'b1);
      no_gaps = (n >= 320 && n < 450);
      r.task_id = ID_W'($urandom);
      r.repeat_req = 1'($urandom);
      r.period = ($urandom_range(9) == 0) ? rand_time() : TIME_W'($urandom_range(300));
      if ($urandom_range(99) < 55 || sh_count < 2) begin
        r.req_type = REQ_ENQUEUE;
        r.deadline = ($urandom_range(19) == 0) ? rand_time() :
                     now_ticks + TIME_W'($urandom_range(400));
      end else begin
        r.req_type = REQ_POLL;
        now_ticks += TIME_W'($urandom_range(60));
        r.deadline = ($urandom_range(24) == 0) ? rand_time() : now_ticks;
      end
      // keep the queue from saturating for long
      if (sh_count > 48 && r.req_type == REQ_ENQUEUE && $urandom_range(1)) begin
        r.req_type = REQ_POLL;
        r.deadline = TIME_MAX;
      end
      send_req(r);
    end
    write_enable(1'b0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_edge_cases();
    test_full_queue();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
